>>> hdl/bcdu_pkg.sv
// Package for the BCD calendar to Unix seconds unit.
// Holds the field widths, the calendar constants, the month table and the
// pipeline stage payload types. No dependencies.
`default_nettype none

package bcdu_pkg;

   // Field widths of one reading and of one result
   localparam int YearBcdWidth   = 8;
   localparam int MonthBcdWidth  = 5;
   localparam int DayBcdWidth    = 6;
   localparam int HourBcdWidth   = 6;
   localparam int MinuteBcdWidth = 7;
   localparam int SecondBcdWidth = 7;
   localparam int ReqDataWidth   = 40;
   localparam int SecondsWidth   = 32;

   // Calendar constants
   localparam logic [15:0] EpochTo2000Days = 16'd10957;
   localparam logic [16:0] SecondsPerDay   = 17'd86400;
   localparam logic [11:0] SecondsPerHour  = 12'd3600;
   localparam logic [5:0]  SecondsPerMin   = 6'd60;
   localparam logic [8:0]  DaysPerYear     = 9'd365;

   // Decoded reading, first stage register
   typedef struct packed {
      logic [6:0] year;
      logic [3:0] month;
      logic [4:0] day;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
      logic       bad;
   } decoded_type;

   // Day count and time of day, second stage register
   typedef struct packed {
      logic [15:0] days;
      logic [16:0] day_secs;
      logic        bad;
   } partial_type;

   // Days before the first of a month in a common year
   function automatic logic [8:0] days_before_month(input logic [3:0] month);
      logic [8:0] d;
      unique case (month)
         4'd2:    d = 9'd31;
         4'd3:    d = 9'd59;
         4'd4:    d = 9'd90;
         4'd5:    d = 9'd120;
         4'd6:    d = 9'd151;
         4'd7:    d = 9'd181;
         4'd8:    d = 9'd212;
         4'd9:    d = 9'd243;
         4'd10:   d = 9'd273;
         4'd11:   d = 9'd304;
         4'd12:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

   // Two BCD digits to binary; top nibble may be narrower than four bits
   function automatic logic [7:0] bcd_to_bin(input logic [3:0] hi, input logic [3:0] lo);
      return 8'({4'd0, hi} * 8'd10) + {4'd0, lo};
   endfunction

endpackage : bcdu_pkg

`default_nettype wire

>>> hdl/bcd_calendar_to_unix_seconds_unit.sv
// BCD calendar to Unix seconds: top level, a three-stage pipeline; depends on bcdu_pkg.
// Stages: BCD decode and range check, day count and time of day, day multiply and time-of-day add.
// Registers: 3 register stages, s1_ff, s2_ff and the result register, in that order.
// Throughput: one reading per cycle; the result register stalls the whole
// pipeline only while a valid result waits on rsp_tready.
// Reset: synchronous, active high; clears every stage valid bit.
`default_nettype none

module bcd_calendar_to_unix_seconds_unit
   import bcdu_pkg::*;
(
   input  wire                     clock,
   input  wire                     reset,
   // year[7:0], month[12:8], day[18:13], hour[24:19], minute[31:25],
   // second[38:32], zero pad [39]
   input  wire [ReqDataWidth-1:0]  req_tdata,
   input  wire                     req_tvalid,
   output logic                    req_tready,
   // unix_seconds[31:0]
   output logic [SecondsWidth-1:0] rsp_tdata,
   // bad_input[0]
   output logic                    rsp_tuser,
   output logic                    rsp_tvalid,
   input  wire                     rsp_tready
);

   logic                    advance;
   logic                    s1_valid_ff, s1_valid_in;
   decoded_type             s1_ff, s1_in;
   logic                    s2_valid_ff, s2_valid_in;
   partial_type             s2_ff, s2_in;
   logic                    out_valid_ff, out_valid_in;
   logic [SecondsWidth-1:0] out_secs_ff, out_secs_in;
   logic                    out_bad_ff, out_bad_in;

   logic [YearBcdWidth-1:0]   year_raw;
   logic [MonthBcdWidth-1:0]  month_raw;
   logic [DayBcdWidth-1:0]    day_raw;
   logic [HourBcdWidth-1:0]   hour_raw;
   logic [MinuteBcdWidth-1:0] minute_raw;
   logic [SecondBcdWidth-1:0] second_raw;
   logic [7:0] year_bin, month_bin, day_bin, hour_bin, minute_bin, second_bin;
   logic       digit_bad, range_bad;

   logic [15:0] year_days;
   logic [15:0] leap_days;
   logic        leap_extra;
   logic [16:0] hour_secs;
   logic [16:0] min_secs;
   logic [SecondsWidth-1:0] day_product;

   // Move every stage together whenever the result register can take data
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = advance;

   // Stage 1: split the fields, decode the digits, check the ranges
   always_comb begin
      year_raw   = req_tdata[7:0];
      month_raw  = req_tdata[12:8];
      day_raw    = req_tdata[18:13];
      hour_raw   = req_tdata[24:19];
      minute_raw = req_tdata[31:25];
      second_raw = req_tdata[38:32];

      digit_bad = (year_raw[7:4] > 4'd9) || (year_raw[3:0] > 4'd9) ||
                  (month_raw[3:0] > 4'd9) || (day_raw[3:0] > 4'd9) ||
                  (hour_raw[3:0] > 4'd9) || (minute_raw[3:0] > 4'd9) ||
                  (second_raw[3:0] > 4'd9);

      year_bin   = bcd_to_bin(year_raw[7:4], year_raw[3:0]);
      month_bin  = bcd_to_bin({3'd0, month_raw[4]}, month_raw[3:0]);
      day_bin    = bcd_to_bin({2'd0, day_raw[5:4]}, day_raw[3:0]);
      hour_bin   = bcd_to_bin({2'd0, hour_raw[5:4]}, hour_raw[3:0]);
      minute_bin = bcd_to_bin({1'b0, minute_raw[6:4]}, minute_raw[3:0]);
      second_bin = bcd_to_bin({1'b0, second_raw[6:4]}, second_raw[3:0]);

      range_bad = (year_bin > 8'd99) || (month_bin == 8'd0) || (month_bin > 8'd12) ||
                  (day_bin == 8'd0) || (day_bin > 8'd31) || (hour_bin > 8'd23) ||
                  (minute_bin > 8'd59) || (second_bin > 8'd59);

      s1_valid_in  = req_tvalid;
      s1_in.year   = year_bin[6:0];
      s1_in.month  = month_bin[3:0];
      s1_in.day    = day_bin[4:0];
      s1_in.hour   = hour_bin[4:0];
      s1_in.minute = minute_bin[5:0];
      s1_in.second = second_bin[5:0];
      s1_in.bad    = digit_bad || range_bad;
   end

   // Stage 2: whole days since the epoch and seconds into the day
   always_comb begin
      year_days  = 16'(s1_ff.year) * 16'(DaysPerYear);
      leap_days  = 16'((8'({1'b0, s1_ff.year}) + 8'd3) >> 2);
      leap_extra = (s1_ff.year[1:0] == 2'd0) && (s1_ff.month > 4'd2);
      hour_secs  = 17'(s1_ff.hour) * 17'(SecondsPerHour);
      min_secs   = 17'(s1_ff.minute) * 17'(SecondsPerMin);

      s2_valid_in    = s1_valid_ff;
      s2_in.days     = EpochTo2000Days + year_days + leap_days +
                       16'(days_before_month(s1_ff.month)) + 16'(leap_extra) +
                       16'(s1_ff.day) - 16'd1;
      s2_in.day_secs = hour_secs + min_secs + 17'(s1_ff.second);
      s2_in.bad      = s1_ff.bad;
   end

   // Stage 3: scale the day count and add the time of day; zero on bad input
   always_comb begin
      day_product  = SecondsWidth'(s2_ff.days) * SecondsWidth'(SecondsPerDay);
      out_valid_in = s2_valid_ff;
      out_bad_in   = s2_ff.bad;
      out_secs_in  = s2_ff.bad ? '0 : day_product + SecondsWidth'(s2_ff.day_secs);
   end

   // Clear valid bits under reset, advance all stages together
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers need no reset
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff       <= s1_in;
         s2_ff       <= s2_in;
         out_secs_ff <= out_secs_in;
         out_bad_ff  <= out_bad_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_secs_ff;
   assign rsp_tuser  = out_bad_ff;

`ifndef SYNTHESIS
   // A flagged result carries a zero timestamp
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("bad result with non-zero timestamp");

   // A good result lies within 2000-01-01 .. 2099-12-31 23:59:59
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |->
         (rsp_tdata >= 32'd946684800) && (rsp_tdata <= 32'd4102444799))
      else $error("timestamp outside the covered century");

   // An accepted reading enters the first stage
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> s1_valid_ff)
      else $error("accepted reading lost at stage one");

   // A stall freezes the inner stages
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(s1_valid_ff) && $stable(s2_valid_ff))
      else $error("pipeline moved during a stall");

   // A stage-two item reaches the result register on the next advance
   assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && advance |=> out_valid_ff)
      else $error("stage two item dropped");
`endif

endmodule : bcd_calendar_to_unix_seconds_unit

`default_nettype wire
